// ----- sv/md5_pkg.sv -----
// Package for the MD5 hash engine: initial chaining values, the sine constant table,
// the shift schedule, the message word schedule and the round functions.
// It has no dependencies. The interfaces and the engine import it.
package md5_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned INDEX_W = 2;

  localparam logic [WORD_W-1:0] INIT_A = 32'h67452301;
  localparam logic [WORD_W-1:0] INIT_B = 32'hefcdab89;
  localparam logic [WORD_W-1:0] INIT_C = 32'h98badcfe;
  localparam logic [WORD_W-1:0] INIT_D = 32'h10325476;

  localparam logic [WORD_W-1:0] PAD_BYTE = 32'h00000080;

  function automatic logic [WORD_W-1:0] md5_sine(input logic [5:0] idx);
    logic [WORD_W-1:0] t;
    case (idx)
      6'd0:  t = 32'hd76aa478;
      6'd1:  t = 32'he8c7b756;
      6'd2:  t = 32'h242070db;
      6'd3:  t = 32'hc1bdceee;
      6'd4:  t = 32'hf57c0faf;
      6'd5:  t = 32'h4787c62a;
      6'd6:  t = 32'ha8304613;
      6'd7:  t = 32'hfd469501;
      6'd8:  t = 32'h698098d8;
      6'd9:  t = 32'h8b44f7af;
      6'd10: t = 32'hffff5bb1;
      6'd11: t = 32'h895cd7be;
      6'd12: t = 32'h6b901122;
      6'd13: t = 32'hfd987193;
      6'd14: t = 32'ha679438e;
      6'd15: t = 32'h49b40821;
      6'd16: t = 32'hf61e2562;
      6'd17: t = 32'hc040b340;
      6'd18: t = 32'h265e5a51;
      6'd19: t = 32'he9b6c7aa;
      6'd20: t = 32'hd62f105d;
      6'd21: t = 32'h02441453;
      6'd22: t = 32'hd8a1e681;
      6'd23: t = 32'he7d3fbc8;
      6'd24: t = 32'h21e1cde6;
      6'd25: t = 32'hc33707d6;
      6'd26: t = 32'hf4d50d87;
      6'd27: t = 32'h455a14ed;
      6'd28: t = 32'ha9e3e905;
      6'd29: t = 32'hfcefa3f8;
      6'd30: t = 32'h676f02d9;
      6'd31: t = 32'h8d2a4c8a;
      6'd32: t = 32'hfffa3942;
      6'd33: t = 32'h8771f681;
      6'd34: t = 32'h6d9d6122;
      6'd35: t = 32'hfde5380c;
      6'd36: t = 32'ha4beea44;
      6'd37: t = 32'h4bdecfa9;
      6'd38: t = 32'hf6bb4b60;
      6'd39: t = 32'hbebfbc70;
      6'd40: t = 32'h289b7ec6;
      6'd41: t = 32'heaa127fa;
      6'd42: t = 32'hd4ef3085;
      6'd43: t = 32'h04881d05;
      6'd44: t = 32'hd9d4d039;
      6'd45: t = 32'he6db99e5;
      6'd46: t = 32'h1fa27cf8;
      6'd47: t = 32'hc4ac5665;
      6'd48: t = 32'hf4292244;
      6'd49: t = 32'h432aff97;
      6'd50: t = 32'hab9423a7;
      6'd51: t = 32'hfc93a039;
      6'd52: t = 32'h655b59c3;
      6'd53: t = 32'h8f0ccc92;
      6'd54: t = 32'hffeff47d;
      6'd55: t = 32'h85845dd1;
      6'd56: t = 32'h6fa87e4f;
      6'd57: t = 32'hfe2ce6e0;
      6'd58: t = 32'ha3014314;
      6'd59: t = 32'h4e0811a1;
      6'd60: t = 32'hf7537e82;
      6'd61: t = 32'hbd3af235;
      6'd62: t = 32'h2ad7d2bb;
      default: t = 32'heb86d391;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] md5_shift(input logic [5:0] idx);
    logic [4:0] s;
    case ({idx[5:4], idx[1:0]})
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] md5_msg_index(input logic [5:0] idx);
    logic [3:0] k;
    logic [3:0] g;
    k = idx[3:0];
    case (idx[5:4])
      2'd0: g = k;
      2'd1: g = 4'd1 + (k << 2) + k;
      2'd2: g = 4'd5 + (k << 1) + k;
      default: g = (k << 3) - k;
    endcase
    return g;
  endfunction

  function automatic logic [WORD_W-1:0] md5_round_fn(input logic [1:0] round,
                                                     input logic [WORD_W-1:0] b,
                                                     input logic [WORD_W-1:0] c,
                                                     input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] f;
    case (round)
      2'd0: f = d ^ (b & (c ^ d));
      2'd1: f = c ^ (d & (b ^ c));
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

endpackage

// ----- sv/md5_if.sv -----
// Valid/ready channel interfaces of the MD5 hash engine: message words in, digest words out.
// Depends on md5_pkg for the field widths.
interface md5_word_if import md5_pkg::*;;
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  data_word;
  logic [COUNT_W-1:0] byte_count;
  logic               last_item;

  modport source (output valid, output data_word, output byte_count, output last_item,
                  input ready);
  modport sink (input valid, input data_word, input byte_count, input last_item,
                output ready);
endinterface

interface md5_digest_if import md5_pkg::*;;
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  digest_word;
  logic [INDEX_W-1:0] word_index;
  logic               last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ----- sv/md5_hash_engine.sv -----
// Streaming MD5 engine: message words in, four digest words out per message.
// Depends on md5_pkg and on the channel interfaces in md5_if.sv.
//
//   channel  direction  word fields                          handshake
//   msg      in         data_word, byte_count, last_item     valid / ready
//   digest   out        digest_word, word_index, last_word   valid / ready
//
// Message words are taken while idle; the sixteenth word of a block starts the compression.
// One compression runs 64 steps of the shared step unit and then one add.
// The final word adds the padding words and one or two compressions.
// The four digest words then leave at one per cycle while digest.ready is high.
// The reset is synchronous; msg.ready is low from the sixteenth word until its block is done.
module md5_hash_engine import md5_pkg::*; (
  input logic           clk,
  input logic           rst,
  md5_word_if.sink      msg,
  md5_digest_if.source  digest
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_COMP = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state;
  logic [2:0]         resume;
  logic [5:0]         step;
  logic [3:0]         fill;
  logic               pad80;
  logic [1:0]         oidx;
  logic [WORD_W-1:0]  chain [4];
  logic [63:0]        msg_bytes;
  logic [WORD_W-1:0]  buffer [16];
  logic [WORD_W-1:0]  a;
  logic [WORD_W-1:0]  b;
  logic [WORD_W-1:0]  c;
  logic [WORD_W-1:0]  d;

  logic               msg_fire;
  logic [COUNT_W-1:0] count_sat;
  logic [WORD_W-1:0]  tail_word;
  logic [63:0]        bit_len;
  logic               buf_we;
  logic [3:0]         buf_addr;
  logic [WORD_W-1:0]  buf_data;
  logic [WORD_W-1:0]  step_sum;
  logic [63:0]        step_rot;
  logic [WORD_W-1:0]  b_next;

  assign msg_fire = msg.valid && msg.ready;
  assign msg.ready = (state == S_IDLE);
  assign bit_len = {msg_bytes[60:0], 3'b000};

  assign digest.valid = (state == S_OUT);
  assign digest.digest_word = chain[oidx];
  assign digest.word_index = oidx;
  assign digest.last_word = (oidx == 2'd3);

  always_comb begin
    if (!msg.last_item || msg.byte_count > 3'd4) begin
      count_sat = 3'd4;
    end else begin
      count_sat = msg.byte_count;
    end
  end

  // The final word keeps its valid bytes and, when under four, the 0x80 marker after them.
  always_comb begin
    case (count_sat)
      3'd0: tail_word = PAD_BYTE;
      3'd1: tail_word = {16'h0000, PAD_BYTE[7:0], msg.data_word[7:0]};
      3'd2: tail_word = {8'h00, PAD_BYTE[7:0], msg.data_word[15:0]};
      3'd3: tail_word = {PAD_BYTE[7:0], msg.data_word[23:0]};
      default: tail_word = msg.data_word;
    endcase
  end

  always_comb begin
    buf_we = 1'b0;
    buf_addr = fill;
    buf_data = msg.data_word;
    case (state)
      S_IDLE: begin
        buf_we = msg_fire;
        buf_data = msg.last_item ? tail_word : msg.data_word;
      end
      S_PAD: begin
        buf_we = 1'b1;
        if (!pad80 && fill == 4'd14) begin
          buf_data = bit_len[31:0];
        end else begin
          buf_data = pad80 ? PAD_BYTE : '0;
        end
      end
      S_LEN: begin
        buf_we = 1'b1;
        buf_addr = 4'd15;
        buf_data = bit_len[63:32];
      end
      default: begin
        buf_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buffer[buf_addr] <= buf_data;
    end
  end

  assign step_sum = a + md5_round_fn(step[5:4], b, c, d) + buffer[md5_msg_index(step)]
                    + md5_sine(step);
  assign step_rot = {step_sum, step_sum} << md5_shift(step);
  assign b_next = b + step_rot[63:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      resume <= S_IDLE;
      step <= '0;
      fill <= '0;
      pad80 <= 1'b0;
      oidx <= '0;
      chain[0] <= INIT_A;
      chain[1] <= INIT_B;
      chain[2] <= INIT_C;
      chain[3] <= INIT_D;
      msg_bytes <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (msg_fire) begin
            fill <= fill + 4'd1;
            msg_bytes <= msg_bytes + 64'(count_sat);
            if (msg.last_item) begin
              pad80 <= (count_sat == 3'd4);
            end
            if (fill == 4'd15) begin
              state <= S_COMP;
              resume <= msg.last_item ? S_PAD : S_IDLE;
              a <= chain[0];
              b <= chain[1];
              c <= chain[2];
              d <= chain[3];
            end else begin
              state <= msg.last_item ? S_PAD : S_IDLE;
            end
          end
        end
        S_PAD: begin
          if (!pad80 && fill == 4'd14) begin
            fill <= 4'd15;
            state <= S_LEN;
          end else begin
            pad80 <= 1'b0;
            fill <= fill + 4'd1;
            if (fill == 4'd15) begin
              state <= S_COMP;
              resume <= S_PAD;
              a <= chain[0];
              b <= chain[1];
              c <= chain[2];
              d <= chain[3];
            end
          end
        end
        S_LEN: begin
          fill <= '0;
          state <= S_COMP;
          resume <= S_OUT;
          a <= chain[0];
          b <= chain[1];
          c <= chain[2];
          d <= chain[3];
        end
        S_COMP: begin
          a <= d;
          b <= b_next;
          c <= b;
          d <= c;
          step <= step + 6'd1;
          if (step == 6'd63) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          state <= resume;
        end
        S_OUT: begin
          if (digest.ready) begin
            oidx <= oidx + 2'd1;
            if (oidx == 2'd3) begin
              chain[0] <= INIT_A;
              chain[1] <= INIT_B;
              chain[2] <= INIT_C;
              chain[3] <= INIT_D;
              msg_bytes <= '0;
              fill <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/md5_checker.sv -----
// Port-level checks for the MD5 hash engine and the bind that attaches them.
// Depends on md5_pkg and on the ports of md5_hash_engine.
module md5_checker import md5_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               msg_ready,
  input logic               digest_valid,
  input logic               digest_ready,
  input logic [INDEX_W-1:0] word_index,
  input logic               last_word
);

  // The engine never takes a message word while a digest is being delivered.
  assert property (@(posedge clk) disable iff (rst) !(msg_ready && digest_valid))
    else $error("Message ready while a digest word is pending.");

  assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid && $stable(word_index))
    else $error("Digest word dropped before it was taken.");

  assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && !last_word |=>
      digest_valid && word_index == $past(word_index) + 2'd1)
    else $error("Digest words out of sequence.");

  assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (last_word == (word_index == 2'd3)))
    else $error("Final digest flag does not match the word position.");

  assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && last_word |=> msg_ready && !digest_valid)
    else $error("Engine not ready for a new message after the digest.");

endmodule

bind md5_hash_engine md5_checker u_md5_checker (
  .clk          (clk),
  .rst          (rst),
  .msg_ready    (msg.ready),
  .digest_valid (digest.valid),
  .digest_ready (digest.ready),
  .word_index   (digest.word_index),
  .last_word    (digest.last_word)
);
